/* rtl/pendulum_state_feedback_current_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pendulum state feedback controller
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PENDULUM_STATE_FEEDBACK_CURRENT_MACROS_SVH
`define PENDULUM_STATE_FEEDBACK_CURRENT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSFC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSFC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/psfc_pkg.sv */
// ----------------------------------------------------------------------------
// psfc_pkg
// Types, constants and the control store of the balance controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psfc_pkg;

    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 72;
    localparam int OPA_W       = 34;
    localparam int OPB_W       = 26;
    localparam int PROD_W      = OPA_W + OPB_W;
    localparam int ACC_W       = 58;
    localparam int STEP_W      = 5;

    localparam logic signed [PROD_W-1:0] TERM_CAP = 60'sd68719476736;

    localparam logic [15:0]        RST_FILTER_COEFF  = 16'd19661;
    localparam logic signed [24:0] RST_GAIN_ANGLE    = 25'sd1920000;
    localparam logic signed [24:0] RST_GAIN_RATE     = 25'sd38400;
    localparam logic signed [24:0] RST_GAIN_POSITION = 25'sd0;
    localparam logic signed [24:0] RST_GAIN_SPEED    = 25'sd0;
    localparam logic signed [24:0] RST_GAIN_YAW      = 25'sd76800;
    localparam logic [19:0]        RST_THROTTLE_GAIN = 20'd200000;
    localparam logic [19:0]        RST_CURRENT_LIMIT = 20'd120000;

    typedef enum logic [2:0] {
        REG_FILTER_COEFF  = 3'd0,
        REG_GAIN_ANGLE    = 3'd1,
        REG_GAIN_RATE     = 3'd2,
        REG_GAIN_POSITION = 3'd3,
        REG_GAIN_SPEED    = 3'd4,
        REG_GAIN_YAW      = 3'd5,
        REG_THROTTLE_GAIN = 3'd6,
        REG_CURRENT_LIMIT = 3'd7
    } t_reg;

    typedef struct packed {
        logic [15:0]        filter_coeff;
        logic signed [24:0] gain_angle;
        logic signed [24:0] gain_rate;
        logic signed [24:0] gain_position;
        logic signed [24:0] gain_speed;
        logic signed [24:0] gain_yaw;
        logic [19:0]        throttle_gain;
        logic [19:0]        current_limit;
    } t_cfg;

    // Multiplier operand pair.
    typedef enum logic [3:0] {
        M_NONE  = 4'd0,
        M_FOLD  = 4'd1,
        M_FNEW  = 4'd2,
        M_ANGLE = 4'd3,
        M_RATE  = 4'd4,
        M_POS   = 4'd5,
        M_SPEED = 4'd6,
        M_THR   = 4'd7,
        M_YAW   = 4'd8
    } t_msel;

    // Scaling of the registered product.
    typedef enum logic [2:0] {
        SH_NONE  = 3'd0,
        SH_S0    = 3'd1,
        SH_S1    = 3'd2,
        SH_S8    = 3'd3,
        SH_S9    = 3'd4,
        SH_CAP16 = 3'd5
    } t_shp;

    // Accumulator operation.
    typedef enum logic [2:0] {
        A_NOP   = 3'd0,
        A_LOAD  = 3'd1,
        A_LOADN = 3'd2,
        A_ADD   = 3'd3,
        A_SUB   = 3'd4,
        A_SPLIT = 3'd5
    } t_aop;

    // State and result writeback.
    typedef enum logic [2:0] {
        W_NONE  = 3'd0,
        W_FILT  = 3'd1,
        W_BTN   = 3'd2,
        W_RIGHT = 3'd3,
        W_LEFT  = 3'd4,
        W_ZERO  = 3'd5,
        W_EMIT  = 3'd6
    } t_wb;

    typedef enum logic [2:0] {
        J_NEXT   = 3'd0,
        J_IFBTN  = 3'd1,
        J_IFSTOP = 3'd2,
        J_GOTO   = 3'd3,
        J_DONE   = 3'd4
    } t_jmp;

    typedef struct packed {
        t_msel             msel;
        t_shp              shp;
        t_aop              aop;
        t_wb               wb;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic is_button;
        logic running;
        logic out_full;
    } t_stat;

    localparam logic [STEP_W-1:0] ADDR_EMIT = 5'd17;
    localparam logic [STEP_W-1:0] ADDR_STOP = 5'd18;
    localparam logic [STEP_W-1:0] ADDR_BTN  = 5'd19;

    localparam t_uword UW_NOP = '{msel: M_NONE, shp: SH_NONE, aop: A_NOP, wb: W_NONE,
                                  jmp: J_DONE, target: '0};

    function automatic t_uword uw(input t_msel m, input t_shp s, input t_aop a,
                                  input t_wb w, input t_jmp j,
                                  input logic [STEP_W-1:0] t);
        t_uword r;
        r.msel   = m;
        r.shp    = s;
        r.aop    = a;
        r.wb     = w;
        r.jmp    = j;
        r.target = t;
        return r;
    endfunction

    function automatic t_uword ucode(input logic [STEP_W-1:0] addr);
        t_uword r;
        case (addr)
            5'd0:  r = uw(M_FOLD,  SH_NONE,  A_NOP,   W_NONE,  J_IFBTN,  ADDR_BTN);
            5'd1:  r = uw(M_FNEW,  SH_NONE,  A_NOP,   W_NONE,  J_NEXT,   '0);
            5'd2:  r = uw(M_NONE,  SH_S0,    A_NOP,   W_NONE,  J_NEXT,   '0);
            5'd3:  r = uw(M_NONE,  SH_S0,    A_LOAD,  W_NONE,  J_NEXT,   '0);
            5'd4:  r = uw(M_NONE,  SH_NONE,  A_ADD,   W_NONE,  J_NEXT,   '0);
            5'd5:  r = uw(M_NONE,  SH_NONE,  A_NOP,   W_FILT,  J_IFSTOP, ADDR_STOP);
            5'd6:  r = uw(M_ANGLE, SH_NONE,  A_NOP,   W_NONE,  J_NEXT,   '0);
            5'd7:  r = uw(M_RATE,  SH_NONE,  A_NOP,   W_NONE,  J_NEXT,   '0);
            5'd8:  r = uw(M_POS,   SH_S0,    A_NOP,   W_NONE,  J_NEXT,   '0);
            5'd9:  r = uw(M_SPEED, SH_S8,    A_LOADN, W_NONE,  J_NEXT,   '0);
            5'd10: r = uw(M_THR,   SH_CAP16, A_SUB,   W_NONE,  J_NEXT,   '0);
            5'd11: r = uw(M_YAW,   SH_CAP16, A_SUB,   W_NONE,  J_NEXT,   '0);
            5'd12: r = uw(M_NONE,  SH_S9,    A_SUB,   W_NONE,  J_NEXT,   '0);
            5'd13: r = uw(M_NONE,  SH_S1,    A_ADD,   W_NONE,  J_NEXT,   '0);
            5'd14: r = uw(M_NONE,  SH_NONE,  A_SPLIT, W_NONE,  J_NEXT,   '0);
            5'd15: r = uw(M_NONE,  SH_NONE,  A_NOP,   W_RIGHT, J_NEXT,   '0);
            5'd16: r = uw(M_NONE,  SH_NONE,  A_NOP,   W_LEFT,  J_NEXT,   '0);
            5'd17: r = uw(M_NONE,  SH_NONE,  A_NOP,   W_EMIT,  J_DONE,   '0);
            5'd18: r = uw(M_NONE,  SH_NONE,  A_NOP,   W_ZERO,  J_GOTO,   ADDR_EMIT);
            5'd19: r = uw(M_NONE,  SH_NONE,  A_NOP,   W_BTN,   J_DONE,   '0);
            default: r = UW_NOP;
        endcase
        return r;
    endfunction

endpackage

/* rtl/psfc_sequencer.sv */
// ----------------------------------------------------------------------------
// psfc_sequencer
// Step counter over the control store, with conditional jumps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pendulum_state_feedback_current_macros.svh"

module psfc_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  psfc_pkg::t_stat  i_stat,
    output psfc_pkg::t_uword o_uw,
    output logic             o_idle
);
    import psfc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_seq_state;

    t_seq_state        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_uword            w_word;
    logic              w_hold;

    assign w_word = ucode(r_step);
    assign w_hold = (w_word.wb == W_EMIT) && i_stat.out_full;
    assign o_uw   = (r_state == S_RUN) ? w_word : UW_NOP;
    assign o_idle = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_step  = '0;
                end
            end
            S_RUN: begin
                if (!w_hold) begin
                    unique case (w_word.jmp)
                        J_NEXT: n_step = r_step + 1'b1;
                        J_IFBTN: begin
                            n_step = i_stat.is_button ? w_word.target : r_step + 1'b1;
                        end
                        J_IFSTOP: begin
                            n_step = i_stat.running ? r_step + 1'b1 : w_word.target;
                        end
                        J_GOTO: n_step = w_word.target;
                        J_DONE: begin
                            n_state = S_IDLE;
                            n_step  = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                            n_step  = '0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    `PSFC_ASSERT_NXT(a_start_at_zero, (r_state == S_IDLE) && i_start,
        (r_state == S_RUN) && (r_step == '0), "program did not start at step zero")
    `PSFC_ASSERT_NXT(a_emit_holds, (r_state == S_RUN) && w_hold,
        (r_state == S_RUN) && $stable(r_step), "result step moved while output was full")

endmodule

/* rtl/psfc_datapath.sv */
// ----------------------------------------------------------------------------
// psfc_datapath
// Shared multiplier, product scaler, accumulator, controller state and the
// result register, all driven by the control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pendulum_state_feedback_current_macros.svh"

module psfc_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_operation,
    input  logic signed [17:0]  i_roll_estimate,
    input  logic signed [19:0]  i_roll_rate,
    input  logic signed [19:0]  i_yaw_rate,
    input  logic signed [31:0]  i_wheel_position,
    input  logic signed [31:0]  i_wheel_speed,
    input  logic signed [15:0]  i_stick_yaw,
    input  logic signed [15:0]  i_stick_throttle,
    input  psfc_pkg::t_cfg      i_cfg,
    input  psfc_pkg::t_uword    i_uw,
    input  logic                i_out_ready,
    output psfc_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    output logic signed [20:0]  o_command_right,
    output logic signed [20:0]  o_command_left,
    output logic                o_running,
    output logic signed [23:0]  o_filtered_roll
);
    import psfc_pkg::*;

    // Latched item.
    logic               r_btn;
    logic signed [17:0] r_roll;
    logic signed [19:0] r_rrate;
    logic signed [27:0] r_yerr;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_spd;
    logic signed [16:0] r_nthr;
    logic signed [27:0] w_yerr;

    // Controller state.
    logic signed [23:0] r_f;
    logic signed [23:0] r_roff;
    logic signed [31:0] r_last_pos;
    logic signed [31:0] r_poff;
    logic               r_run;

    // Arithmetic pipeline.
    logic signed [OPA_W-1:0]  r_a, n_a;
    logic signed [OPB_W-1:0]  r_b, n_b;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_term, n_term;
    logic signed [ACC_W-1:0]  r_acc, r_acc2;
    logic signed [37:0]       w_cap;
    logic [16:0]              w_cinv;
    logic signed [24:0]       w_fdiff;
    logic signed [32:0]       w_pdiff;

    // Writeback helpers.
    logic signed [ACC_W-1:0]  w_fsh;
    logic signed [23:0]       w_fnew;
    logic signed [ACC_W-1:0]  w_fin_src, w_fin_bias, w_fin_q, w_lim;
    logic signed [20:0]       w_fin;
    logic signed [20:0]       r_cr, r_cl;

    // Result register.
    logic               r_ov;
    logic signed [20:0] r_o_cr, r_o_cl;
    logic               r_o_run;
    logic signed [23:0] r_o_f;
    logic               w_out_full, w_emit;

    assign w_yerr = -(28'(i_stick_yaw) * 28'sd360) - (28'(i_yaw_rate) <<< 7);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_btn   <= i_operation;
            r_roll  <= i_roll_estimate;
            r_rrate <= i_roll_rate;
            r_yerr  <= w_yerr;
            r_pos   <= i_wheel_position;
            r_spd   <= i_wheel_speed;
            r_nthr  <= -(17'(i_stick_throttle));
        end
    end

    assign w_cinv  = 17'h10000 - {1'b0, i_cfg.filter_coeff};
    assign w_fdiff = 25'(r_f) - 25'(r_roff);
    assign w_pdiff = 33'(r_pos) - 33'(r_poff);

    always_comb begin
        n_a = '0;
        n_b = '0;
        unique case (i_uw.msel)
            M_NONE: begin
                n_a = '0;
                n_b = '0;
            end
            M_FOLD: begin
                n_a = OPA_W'(r_f);
                n_b = {10'd0, i_cfg.filter_coeff};
            end
            M_FNEW: begin
                n_a = OPA_W'($signed({r_roll, 8'd0}));
                n_b = {9'd0, w_cinv};
            end
            M_ANGLE: begin
                n_a = OPA_W'(w_fdiff);
                n_b = OPB_W'(i_cfg.gain_angle);
            end
            M_RATE: begin
                n_a = OPA_W'(r_rrate);
                n_b = OPB_W'(i_cfg.gain_rate);
            end
            M_POS: begin
                n_a = OPA_W'(w_pdiff);
                n_b = OPB_W'(i_cfg.gain_position);
            end
            M_SPEED: begin
                n_a = OPA_W'(r_spd);
                n_b = OPB_W'(i_cfg.gain_speed);
            end
            M_THR: begin
                n_a = OPA_W'(r_nthr);
                n_b = {6'd0, i_cfg.throttle_gain};
            end
            M_YAW: begin
                n_a = OPA_W'(r_yerr);
                n_b = OPB_W'(i_cfg.gain_yaw);
            end
            default: begin
                n_a = '0;
                n_b = '0;
            end
        endcase
    end

    always_comb begin
        if (r_prod > TERM_CAP) begin
            w_cap = 38'(TERM_CAP);
        end else if (r_prod < -TERM_CAP) begin
            w_cap = -(38'(TERM_CAP));
        end else begin
            w_cap = 38'(r_prod);
        end
    end

    always_comb begin
        n_term = r_term;
        unique case (i_uw.shp)
            SH_NONE:  n_term = r_term;
            SH_S0:    n_term = ACC_W'(r_prod);
            SH_S1:    n_term = ACC_W'(r_prod <<< 1);
            SH_S8:    n_term = ACC_W'(r_prod <<< 8);
            SH_S9:    n_term = ACC_W'(r_prod <<< 9);
            SH_CAP16: n_term = ACC_W'($signed({w_cap, 16'd0}));
            default:  n_term = r_term;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_prod <= r_a * r_b;
        r_term <= n_term;
        unique case (i_uw.aop)
            A_NOP:   r_acc <= r_acc;
            A_LOAD:  r_acc <= r_term;
            A_LOADN: r_acc <= -r_term;
            A_ADD:   r_acc <= r_acc + r_term;
            A_SUB:   r_acc <= r_acc - r_term;
            A_SPLIT: begin
                r_acc  <= r_acc + r_term;
                r_acc2 <= r_term - r_acc;
            end
            default: r_acc <= r_acc;
        endcase
    end

    assign w_fsh = r_acc >>> 16;

    always_comb begin
        if (w_fsh > 58'sd8388607) begin
            w_fnew = 24'sh7FFFFF;
        end else if (w_fsh < -58'sd8388608) begin
            w_fnew = 24'sh800000;
        end else begin
            w_fnew = 24'(w_fsh);
        end
    end

    assign w_fin_src  = (i_uw.wb == W_LEFT) ? r_acc2 : r_acc;
    assign w_fin_bias = w_fin_src + (w_fin_src[ACC_W-1] ? 58'sd16777215 : 58'sd0);
    assign w_fin_q    = w_fin_bias >>> 24;
    assign w_lim      = $signed({38'd0, i_cfg.current_limit});

    always_comb begin
        if (w_fin_q > w_lim) begin
            w_fin = 21'(w_lim);
        end else if (w_fin_q < -w_lim) begin
            w_fin = 21'(-w_lim);
        end else begin
            w_fin = 21'(w_fin_q);
        end
    end

    assign w_out_full = r_ov && !i_out_ready;
    assign w_emit     = (i_uw.wb == W_EMIT) && !w_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f        <= '0;
            r_roff     <= '0;
            r_last_pos <= '0;
            r_poff     <= '0;
            r_run      <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_uw.wb == W_FILT) begin
                r_f        <= w_fnew;
                r_last_pos <= r_pos;
            end
            if (i_uw.wb == W_BTN) begin
                r_run  <= !r_run;
                r_roff <= r_f;
                r_poff <= r_last_pos;
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_uw.wb)
            W_RIGHT: r_cr <= w_fin;
            W_LEFT:  r_cl <= w_fin;
            W_ZERO: begin
                r_cr <= '0;
                r_cl <= '0;
            end
            default: begin
                r_cr <= r_cr;
                r_cl <= r_cl;
            end
        endcase
        if (w_emit) begin
            r_o_cr  <= r_cr;
            r_o_cl  <= r_cl;
            r_o_run <= r_run;
            r_o_f   <= r_f;
        end
    end

    assign o_stat.is_button = r_btn;
    assign o_stat.running   = r_run;
    assign o_stat.out_full  = w_out_full;
    assign o_out_valid      = r_ov;
    assign o_command_right  = r_o_cr;
    assign o_command_left   = r_o_cl;
    assign o_running        = r_o_run;
    assign o_filtered_roll  = r_o_f;

    `PSFC_ASSERT_IMP(a_stop_zero, r_ov && !r_o_run,
        (r_o_cr == '0) && (r_o_cl == '0), "stopped result carries nonzero command")
    `PSFC_ASSERT_NXT(a_btn_toggles, i_uw.wb == W_BTN,
        r_run != $past(r_run), "button step did not toggle the run state")

endmodule

/* rtl/pendulum_state_feedback_current.sv */
// ----------------------------------------------------------------------------
// pendulum_state_feedback_current
// Balance controller for a two-wheeled pendulum: right and left motor current
// commands from attitude, wheel state and stick values.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel. Bit 0 of s_axis_tuser selects a control
// tick (0) or a button press (1); s_axis_tdata carries the sensor and stick
// fields. A button beat toggles running, captures the roll and position
// offsets and gives no result. A tick gives one m_axis beat with both commands,
// the run flag and the filtered roll.
// Registers are written on the cfg channel, which is always ready. The user must
// write them only while the block is idle; the block itself does not enforce it.
// One shared 34 by 26 bit multiplier does all products under a 20-step
// program. A stopped tick skips the gain steps, zeroes both commands and goes
// to the result step; a button press jumps from the first step to the button
// step. s_axis_tready is high only while the program is idle, so a new beat is
// taken only after the previous item's program has finished.
// The result register lets the next item run while a result waits; if the
// receiver still stalls when the next result is due, the program holds on
// its final step. Reset stops the controller, clears the filter and offsets,
// and loads the default registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pendulum_state_feedback_current (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // roll_estimate, roll_rate, yaw_rate, wheel_position, wheel_speed,
    // stick_yaw, stick_throttle, zero fill
    input  logic [psfc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // operation
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // command_right, command_left, running, filtered_roll, zero fill
    output logic [psfc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [2:0]                         i_cfg_addr,
    input  logic [24:0]                        i_cfg_data
);
    import psfc_pkg::*;

    t_cfg               r_cfg;
    t_uword             w_uw;
    t_stat              w_stat;
    logic               w_idle;
    logic               w_accept;
    logic signed [20:0] w_cr, w_cl;
    logic               w_run;
    logic signed [23:0] w_froll;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = w_idle;
    assign w_accept      = s_axis_tvalid && w_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_coeff  <= RST_FILTER_COEFF;
            r_cfg.gain_angle    <= RST_GAIN_ANGLE;
            r_cfg.gain_rate     <= RST_GAIN_RATE;
            r_cfg.gain_position <= RST_GAIN_POSITION;
            r_cfg.gain_speed    <= RST_GAIN_SPEED;
            r_cfg.gain_yaw      <= RST_GAIN_YAW;
            r_cfg.throttle_gain <= RST_THROTTLE_GAIN;
            r_cfg.current_limit <= RST_CURRENT_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_addr))
                REG_FILTER_COEFF:  r_cfg.filter_coeff  <= i_cfg_data[15:0];
                REG_GAIN_ANGLE:    r_cfg.gain_angle    <= $signed(i_cfg_data);
                REG_GAIN_RATE:     r_cfg.gain_rate     <= $signed(i_cfg_data);
                REG_GAIN_POSITION: r_cfg.gain_position <= $signed(i_cfg_data);
                REG_GAIN_SPEED:    r_cfg.gain_speed    <= $signed(i_cfg_data);
                REG_GAIN_YAW:      r_cfg.gain_yaw      <= $signed(i_cfg_data);
                REG_THROTTLE_GAIN: r_cfg.throttle_gain <= i_cfg_data[19:0];
                REG_CURRENT_LIMIT: r_cfg.current_limit <= i_cfg_data[19:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    psfc_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_stat  (w_stat),
        .o_uw    (w_uw),
        .o_idle  (w_idle)
    );

    psfc_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (w_accept),
        .i_operation      (s_axis_tuser),
        .i_roll_estimate  ($signed(s_axis_tdata[17:0])),
        .i_roll_rate      ($signed(s_axis_tdata[37:18])),
        .i_yaw_rate       ($signed(s_axis_tdata[57:38])),
        .i_wheel_position ($signed(s_axis_tdata[89:58])),
        .i_wheel_speed    ($signed(s_axis_tdata[121:90])),
        .i_stick_yaw      ($signed(s_axis_tdata[137:122])),
        .i_stick_throttle ($signed(s_axis_tdata[153:138])),
        .i_cfg            (r_cfg),
        .i_uw             (w_uw),
        .i_out_ready      (m_axis_tready),
        .o_stat           (w_stat),
        .o_out_valid      (m_axis_tvalid),
        .o_command_right  (w_cr),
        .o_command_left   (w_cl),
        .o_running        (w_run),
        .o_filtered_roll  (w_froll)
    );

    assign m_axis_tdata = {5'd0, w_froll, w_run, w_cl, w_cr};

endmodule
